// ----- rtl/dfs_pkg.sv -----
// Shared types and constants for the drive fault supervisor.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
`default_nettype none

package dfs_pkg;

  // Field widths of the transactions.
  localparam int POS_W    = 32;
  localparam int IQ_W     = 18;
  localparam int TQ_W     = 24;
  localparam int GEAR_W   = 16;
  localparam int KT_W     = 16;
  localparam int TOL_W    = 32;
  localparam int RATED_W  = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GEAR_NUM   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GEAR_DEN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TORQUE_K   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_TOL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TORQUE_TOL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RATED_CUR  = 3'd5;

  // Torque prediction: current in mA times Kt in mNm/A gives mNm * 1000.
  localparam int DEN_SCALE = 1000;

  localparam logic [31:0] PRED_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] PRED_MIN = 32'h8000_0000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_DSTART,
    S_DWAIT,
    S_POST1,
    S_POST2,
    S_POST3
  } dfs_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic mul1;
    logic mul2;
    logic div_start;
    logic post1;
    logic post2;
    logic commit;
  } dfs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
  } dfs_sts_t;

endpackage

`default_nettype wire

// ----- rtl/dfs_ifs.sv -----
// Valid/ready channel interfaces for the drive fault supervisor.
// Input tick, result and configuration write channels. Depends on dfs_pkg.
`default_nettype none

interface dfs_in_if import dfs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [POS_W-1:0]        motor_position;
  logic [POS_W-1:0]        load_position;
  logic signed [IQ_W-1:0]  current_q;
  logic                    torque_valid;
  logic signed [TQ_W-1:0]  torque_measured;

  modport source (output valid, motor_position, load_position, current_q,
                  torque_valid, torque_measured, input ready);
  modport sink   (input valid, motor_position, load_position, current_q,
                  torque_valid, torque_measured, output ready);
endinterface

interface dfs_out_if import dfs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              transmission_trip;
  logic              torque_trip;
  logic [31:0]       position_discrepancy;
  logic [31:0]       torque_discrepancy_out;
  logic [31:0]       thermal_level;

  modport source (output valid, transmission_trip, torque_trip, position_discrepancy,
                  torque_discrepancy_out, thermal_level, input ready);
  modport sink   (input valid, transmission_trip, torque_trip, position_discrepancy,
                  torque_discrepancy_out, thermal_level, output ready);
endinterface

interface dfs_cfg_if import dfs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DAT_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/dfs_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Unsigned dividend of DW bits by a nonzero divisor of VW bits. No dependencies.
`default_nettype none

module dfs_div #(
  parameter int DW = 48,
  parameter int VW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [DW-1:0] quotient,
  output logic          done
);

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [VW:0]   trial;
  logic [VW:0]   diff;

  assign trial = {rem_r, quo_r[DW-1]};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    cnt_nxt = cnt_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = CW'(DW);
    end else if (cnt_r != '0) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = diff[VW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[VW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign quotient = quo_r;
  assign done     = (cnt_r == '0);

endmodule

`default_nettype wire

// ----- rtl/dfs_ctrl.sv -----
// Sequencing state machine for the drive fault supervisor.
// Drives the datapath commands and both channel handshakes. Depends on dfs_pkg.
`default_nettype none

module dfs_ctrl import dfs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dfs_sts_t sts,
  output dfs_cmd_t cmd
);

  dfs_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  // The result register may be refilled when empty or when drained this cycle.
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_DSTART;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts.div_done) begin
          state_nxt = S_POST1;
        end
      end
      S_POST1: begin
        cmd.post1 = 1'b1;
        state_nxt = S_POST2;
      end
      S_POST2: begin
        cmd.post2 = 1'b1;
        state_nxt = S_POST3;
      end
      S_POST3: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- rtl/dfs_datapath.sv -----
// Datapath of the drive fault supervisor: configuration registers, multipliers,
// two iterative dividers, thermal accumulator and result register.
// Depends on dfs_pkg and dfs_div.
`default_nettype none

module dfs_datapath import dfs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration write
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  // input tick
  input  logic [POS_W-1:0]     motor_position,
  input  logic [POS_W-1:0]     load_position,
  input  logic [IQ_W-1:0]      current_q,
  input  logic                 torque_valid,
  input  logic [TQ_W-1:0]      torque_measured,
  // control
  input  dfs_cmd_t             cmd,
  output dfs_sts_t             sts,
  // result
  output logic                 transmission_trip,
  output logic                 torque_trip,
  output logic [31:0]          position_discrepancy,
  output logic [31:0]          torque_discrepancy_out,
  output logic [31:0]          thermal_level
);

  localparam int PPROD_W = POS_W + GEAR_W;           // motor * denominator
  localparam int TQ1_W   = IQ_W + KT_W;              // |iq| * Kt
  localparam int TQ2_W   = TQ1_W + GEAR_W;           // |iq| * Kt * numerator
  localparam int TDEN_W  = GEAR_W + 10;              // 1000 * denominator
  localparam int SQ_W    = 2 * IQ_W - 10;            // |iq|^2 >> 10

  // Configuration registers.
  logic [GEAR_W-1:0]  gnum_r, gden_r;
  logic [KT_W-1:0]    kt_r;
  logic [TOL_W-1:0]   ttol_r, qtol_r;
  logic [RATED_W-1:0] rated_r;

  // Latched tick.
  logic [POS_W-1:0]   motor_r, load_r;
  logic [IQ_W-1:0]    iq_r;
  logic               tvalid_r;
  logic [TQ_W-1:0]    tmeas_r;

  // Intermediate products and results.
  logic [PPROD_W-1:0] pprod_r;
  logic [TQ1_W-1:0]   tq1_r;
  logic [TQ2_W-1:0]   tq2_r;
  logic [SQ_W-1:0]    sq_r;
  logic [SQ_W-1:0]    rsq_r;
  logic [GEAR_W-1:0]  pdiv_r;
  logic [TDEN_W-1:0]  tdiv_r;
  logic               up_r;
  logic [SQ_W-1:0]    delta_r;
  logic [31:0]        pdiff_r;
  logic [31:0]        pred_r;
  logic [31:0]        pmag_r;
  logic [32:0]        tdiff_r;

  // State.
  logic [31:0]        therm_r, therm_nxt;
  logic [31:0]        held_r;

  // Result register.
  logic               ttrip_r, qtrip_r;
  logic [31:0]        pos_out_r, tq_out_r, therm_out_r;

  logic [IQ_W-1:0]    iq_abs;
  logic [2*IQ_W-1:0]  iq_sq;
  logic [2*RATED_W-1:0] rated_sq;
  logic [GEAR_W-1:0]  gden_eff;
  logic [PPROD_W-1:0] pquo;
  logic [TQ2_W-1:0]   tquo;
  logic               pdone, tdone;
  logic [31:0]        pred_nxt;
  logic [32:0]        sum_up;
  logic [31:0]        tmag;

  assign iq_abs   = iq_r[IQ_W-1] ? (~iq_r + IQ_W'(1)) : iq_r;
  assign iq_sq    = {{IQ_W{1'b0}}, iq_abs} * {{IQ_W{1'b0}}, iq_abs};
  assign rated_sq = {{RATED_W{1'b0}}, rated_r} * {{RATED_W{1'b0}}, rated_r};
  assign gden_eff = (gden_r == '0) ? GEAR_W'(1) : gden_r;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gnum_r  <= GEAR_W'(1);
      gden_r  <= GEAR_W'(1);
      kt_r    <= '0;
      ttol_r  <= '1;
      qtol_r  <= '1;
      rated_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GEAR_NUM:   gnum_r  <= cfg_data[GEAR_W-1:0];
        REG_GEAR_DEN:   gden_r  <= cfg_data[GEAR_W-1:0];
        REG_TORQUE_K:   kt_r    <= cfg_data[KT_W-1:0];
        REG_TRANS_TOL:  ttol_r  <= cfg_data[TOL_W-1:0];
        REG_TORQUE_TOL: qtol_r  <= cfg_data[TOL_W-1:0];
        REG_RATED_CUR:  rated_r <= cfg_data[RATED_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Dividers: position scaling and torque prediction run side by side.
  dfs_div #(.DW(PPROD_W), .VW(GEAR_W)) u_pdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (pprod_r),
    .divisor  (pdiv_r),
    .quotient (pquo),
    .done     (pdone)
  );

  dfs_div #(.DW(TQ2_W), .VW(TDEN_W)) u_tdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (tq2_r),
    .divisor  (tdiv_r),
    .quotient (tquo),
    .done     (tdone)
  );

  assign sts.div_done = pdone && tdone;

  // Signed prediction from the magnitude quotient, saturated to 32 bits.
  always_comb begin
    if (!iq_r[IQ_W-1]) begin
      pred_nxt = (tquo[TQ2_W-1:31] != '0) ? PRED_MAX : tquo[31:0];
    end else if ((tquo[TQ2_W-1:32] != '0) || (tquo[31] && (tquo[30:0] != '0))) begin
      pred_nxt = PRED_MIN;
    end else begin
      pred_nxt = ~tquo[31:0] + 32'd1;
    end
  end

  // Thermal update: add the excess with saturation, or decay with a floor at zero.
  assign sum_up = {1'b0, therm_r} + 33'(delta_r);
  always_comb begin
    if (up_r) begin
      therm_nxt = sum_up[32] ? '1 : sum_up[31:0];
    end else if (therm_r > 32'(delta_r)) begin
      therm_nxt = therm_r - 32'(delta_r);
    end else begin
      therm_nxt = '0;
    end
  end

  assign tmag = tdiff_r[32] ? (~tdiff_r[31:0] + 32'd1) : tdiff_r[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      therm_r <= '0;
      held_r  <= '0;
    end else begin
      if (cmd.post1) begin
        therm_r <= therm_nxt;
      end
      if (cmd.commit && tvalid_r) begin
        held_r <= tmag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      motor_r  <= motor_position;
      load_r   <= load_position;
      iq_r     <= current_q;
      tvalid_r <= torque_valid;
      tmeas_r  <= torque_measured;
    end
    if (cmd.mul1) begin
      pprod_r <= {{GEAR_W{1'b0}}, motor_r} * {{POS_W{1'b0}}, gden_r};
      tq1_r   <= {{KT_W{1'b0}}, iq_abs} * {{IQ_W{1'b0}}, kt_r};
      sq_r    <= iq_sq[2*IQ_W-1:10];
      pdiv_r  <= (gnum_r == '0) ? GEAR_W'(1) : gnum_r;
      tdiv_r  <= {10'd0, gden_eff} * TDEN_W'(DEN_SCALE);
    end
    if (cmd.mul2) begin
      tq2_r <= {{GEAR_W{1'b0}}, tq1_r} * {{TQ1_W{1'b0}}, gnum_r};
      rsq_r <= SQ_W'(rated_sq[2*RATED_W-1:10]);
    end
    if (cmd.div_start) begin
      up_r    <= sq_r > rsq_r;
      delta_r <= (sq_r > rsq_r) ? (sq_r - rsq_r) : ((rsq_r - sq_r) >> 4);
    end
    if (cmd.post1) begin
      pdiff_r <= pquo[31:0] - load_r;
      pred_r  <= pred_nxt;
    end
    if (cmd.post2) begin
      pmag_r  <= pdiff_r[31] ? (~pdiff_r + 32'd1) : pdiff_r;
      tdiff_r <= {pred_r[31], pred_r} - {{(33 - TQ_W){tmeas_r[TQ_W-1]}}, tmeas_r};
    end
    if (cmd.commit) begin
      ttrip_r     <= pmag_r > ttol_r;
      qtrip_r     <= tvalid_r && (tmag > qtol_r);
      pos_out_r   <= pmag_r;
      tq_out_r    <= tvalid_r ? tmag : held_r;
      therm_out_r <= therm_r;
    end
  end

  assign transmission_trip      = ttrip_r;
  assign torque_trip            = qtrip_r;
  assign position_discrepancy   = pos_out_r;
  assign torque_discrepancy_out = tq_out_r;
  assign thermal_level          = therm_out_r;

endmodule

`default_nettype wire

// ----- rtl/drive_fault_supervisor.sv -----
// Top level of the drive fault supervisor: transmission, torque and I^2t checks.
// Instantiates dfs_ctrl and dfs_datapath; uses dfs_pkg and the dfs_ifs channels.
//
//   Channel   Direction  Handshake     Carries
//   in_ch     sink       valid/ready   one supervisor tick: encoder positions, iq, torque
//   out_ch    source     valid/ready   trip flags, discrepancies, thermal level
//   cfg_ch    sink       valid/ready   register index and write data, always ready
//
// Each tick passes from acceptance through the multiply steps and the divider launch to the
// 48- and 50-bit iterative dividers (one quotient bit per cycle), which run longest, and
// then through the post-processing steps before the next tick can be accepted.
// Reset is synchronous and active low; it restores the register defaults and clears the
// thermal accumulator and the held torque discrepancy.
// The result register lets a new tick be accepted while the previous result is still
// waiting; a tick only stalls at its final step if that result has not been taken yet.
`default_nettype none

module drive_fault_supervisor import dfs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  dfs_in_if.sink     in_ch,
  dfs_out_if.source  out_ch,
  dfs_cfg_if.sink    cfg_ch
);

  dfs_cmd_t cmd;
  dfs_sts_t sts;

  // Register writes are taken on any cycle; software must write only while idle, which the block does not enforce.
  assign cfg_ch.ready = 1'b1;

  // The controller owns the handshakes and walks each transaction through
  // multiply, divide and post-processing steps.
  dfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds configuration, the thermal state and the result register.
  dfs_datapath u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_ch.valid),
    .cfg_index              (cfg_ch.index),
    .cfg_data               (cfg_ch.data),
    .motor_position         (in_ch.motor_position),
    .load_position          (in_ch.load_position),
    .current_q              (in_ch.current_q),
    .torque_valid           (in_ch.torque_valid),
    .torque_measured        (in_ch.torque_measured),
    .cmd                    (cmd),
    .sts                    (sts),
    .transmission_trip      (out_ch.transmission_trip),
    .torque_trip            (out_ch.torque_trip),
    .position_discrepancy   (out_ch.position_discrepancy),
    .torque_discrepancy_out (out_ch.torque_discrepancy_out),
    .thermal_level          (out_ch.thermal_level)
  );

endmodule

`default_nettype wire

// ----- rtl/dfs_checker.sv -----
// Port-level checks for the drive fault supervisor, attached by bind.
// Depends only on the top level's ports.
`default_nettype none

module dfs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        transmission_trip,
  input logic        torque_trip,
  input logic [31:0] position_discrepancy,
  input logic [31:0] torque_discrepancy_out,
  input logic [31:0] thermal_level
);

  // A stalled result holds its discrepancy and thermal values.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(position_discrepancy)
      && $stable(torque_discrepancy_out) && $stable(thermal_level))
    else $error("result changed while stalled");

  // One tick at a time: the block is busy right after taking a transaction.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // A trip needs a nonzero discrepancy.
  a_trip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (transmission_trip || torque_trip) |->
      (!transmission_trip || position_discrepancy != 32'd0) &&
      (!torque_trip || torque_discrepancy_out != 32'd0))
    else $error("trip with zero discrepancy");

  // The position magnitude never exceeds 2^31.
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(position_discrepancy[31] && position_discrepancy[30:0] != 31'd0))
    else $error("position discrepancy out of range");

endmodule

bind drive_fault_supervisor dfs_checker u_dfs_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .in_valid               (in_ch.valid),
  .in_ready               (in_ch.ready),
  .out_valid              (out_ch.valid),
  .out_ready              (out_ch.ready),
  .transmission_trip      (out_ch.transmission_trip),
  .torque_trip            (out_ch.torque_trip),
  .position_discrepancy   (out_ch.position_discrepancy),
  .torque_discrepancy_out (out_ch.torque_discrepancy_out),
  .thermal_level          (out_ch.thermal_level)
);

`default_nettype wire
